FILE: rtl/vsa_pkg.sv
// shared types, constants and helpers of the vertical speed averager
package vsa_pkg;

  localparam int AVG_DEPTH_DEF = 4;

  localparam int ALT_W      = 22;
  localparam int MS_W       = 16;
  localparam int RATE_W     = 32;
  localparam int DB_W       = 10;
  localparam int SCALE_W    = 22;
  localparam int FRAC_W     = 16;
  localparam int MS_PER_S   = 1000;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [DB_W-1:0]    DEADBAND_RST = 10'd10;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 22'd1290079;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND = 2'd0,
    REG_SCALE    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] altitude_cm;
    logic [MS_W-1:0]         elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] vertical_speed;
    logic                     primed_only;
  } speed_t;

  // clamp a wide signed value to 32 bits signed
  function automatic logic signed [RATE_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [RATE_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[RATE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/vertical_speed_averager_unit.sv
// vertical speed averager: rate divide, ring average, deadband and q16 scaling
//
//   channel  | signals                                   | dir | handshake
//   sample   | sample_valid, sample_stall, sample        | in  | valid / stall
//   speed    | speed_valid, speed_stall, speed           | out | valid / stall
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | valid / ready
//
// a normal word runs a 32-step restoring divide and a 22-step shift-add
// multiply, both on one shared adder, before it is emitted.
// a depth that is not a power of two adds a prep state and a divide by the
// depth of (PROD_W - 16) steps on the same adder. a priming word goes straight to emit.
// reset is synchronous; the sample side stalls whenever the sequencer is busy.
// the speed register holds a finished word while the next sample is taken.
module vertical_speed_averager_unit #(
  parameter int AVG_DEPTH = vsa_pkg::AVG_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  vsa_pkg::sample_t                 sample,
  output logic                             speed_valid,
  input  logic                             speed_stall,
  output vsa_pkg::speed_t                  speed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ALT_W   = vsa_pkg::ALT_W;
  localparam int MS_W    = vsa_pkg::MS_W;
  localparam int RATE_W  = vsa_pkg::RATE_W;
  localparam int DB_W    = vsa_pkg::DB_W;
  localparam int SCALE_W = vsa_pkg::SCALE_W;
  localparam int FRAC_W  = vsa_pkg::FRAC_W;
  localparam int LOG_D   = $clog2(AVG_DEPTH);
  localparam int TOTAL_W = RATE_W + LOG_D;
  localparam int PROD_W  = TOTAL_W + SCALE_W;
  localparam int QW      = PROD_W - FRAC_W;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int SIDX_W  = $clog2(SCALE_W);
  localparam int THR_W   = DB_W + $clog2(AVG_DEPTH + 1);
  localparam bit POW2    = ((AVG_DEPTH & (AVG_DEPTH - 1)) == 0);
  localparam logic [LOG_D-1:0] LAST_SLOT = LOG_D'(AVG_DEPTH - 1);

  typedef enum logic [3:0] {
    IDLE, LOAD, DIV, RING, CHK, MUL, PREP, FDIV, FIN, EMIT
  } state_t;

  state_t                    state;
  logic [DB_W-1:0]           deadband;
  logic [SCALE_W-1:0]        scale;
  logic signed [ALT_W-1:0]   last_alt;
  logic signed [RATE_W-1:0]  ring [AVG_DEPTH];
  logic [LOG_D-1:0]          slot;
  logic signed [TOTAL_W-1:0] total;
  logic                      have_prev;
  logic signed [ALT_W:0]     diff;
  logic                      neg;
  logic [MS_W-1:0]           dsr;
  logic [MS_W-1:0]           rem;
  logic [PROD_W-1:0]         acc;
  logic [CNT_W-1:0]          cnt;
  logic                      dead;
  logic                      primed;
  logic signed [RATE_W-1:0]  vs;

  // shared adder
  logic [PROD_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic [MS_W:0]     trial_top;
  logic              trial_ok;

  logic [ALT_W-1:0]          diff_mag;
  logic [RATE_W-1:0]         dvd_load;
  logic [RATE_W-1:0]         q32;
  logic signed [RATE_W-1:0]  rate_new;
  logic signed [TOTAL_W-1:0] total_next;
  logic [TOTAL_W-1:0]        tot_mag;
  logic [THR_W-1:0]          thr;
  logic signed [PROD_W-1:0]  acc_s;
  logic signed [PROD_W-1:0]  shifted;
  logic signed [QW:0]        qsig;
  logic signed [RATE_W-1:0]  fin_val;
  logic                      accept;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != IDLE);
  assign accept       = sample_valid && (state == IDLE);

  assign trial_top = {rem, acc[PROD_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      DIV, FDIV: begin
        alu_a   = PROD_W'(trial_top);
        alu_b   = PROD_W'(dsr);
        alu_sub = 1'b1;
      end
      MUL: begin
        alu_a = acc << 1;
        if (scale[cnt[SIDX_W-1:0]]) begin
          alu_b = {{(PROD_W-TOTAL_W){total[TOTAL_W-1]}}, total};
        end
      end
      PREP: begin
        // floor divide of a negative value: magnitude plus depth minus one
        alu_a = acc[PROD_W-1] ? PROD_W'(~acc[PROD_W-1:FRAC_W])
                              : PROD_W'(acc[PROD_W-1:FRAC_W]);
        if (acc[PROD_W-1]) begin
          alu_b = PROD_W'(AVG_DEPTH);
        end
      end
      default: begin
        alu_a   = '0;
      end
    endcase
  end

  assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + PROD_W'(alu_sub);
  assign trial_ok = !alu_sum[PROD_W-1];

  // rate magnitude times 1000 from the registered difference
  assign diff_mag = diff[ALT_W] ? ALT_W'(-diff) : ALT_W'(diff);
  assign dvd_load = RATE_W'(diff_mag) * RATE_W'(vsa_pkg::MS_PER_S);

  // sign and clamp the rate quotient
  assign q32 = acc[RATE_W-1:0];
  always_comb begin
    if (neg) begin
      rate_new = (q32 > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q32);
    end else begin
      rate_new = q32[RATE_W-1] ? 32'sh7FFF_FFFF : $signed(q32);
    end
  end

  assign total_next = total - TOTAL_W'(ring[slot]) + TOTAL_W'(rate_new);

  assign tot_mag = total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);
  assign thr     = THR_W'(deadband) * THR_W'(AVG_DEPTH);

  assign acc_s   = $signed(acc);
  assign shifted = acc_s >>> (FRAC_W + LOG_D);
  assign qsig    = neg ? -$signed({1'b0, acc[QW-1:0]}) : $signed({1'b0, acc[QW-1:0]});

  always_comb begin
    if (dead) begin
      fin_val = '0;
    end else if (POW2) begin
      fin_val = vsa_pkg::sat32(64'(shifted));
    end else begin
      fin_val = vsa_pkg::sat32(64'(qsig));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      deadband    <= vsa_pkg::DEADBAND_RST;
      scale       <= vsa_pkg::SCALE_RST;
      have_prev   <= 1'b0;
      slot        <= '0;
      cnt         <= '0;
      speed_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vsa_pkg::REG_DEADBAND: deadband <= cfg_data[DB_W-1:0];
          vsa_pkg::REG_SCALE:    scale    <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      // in EMIT the word is reloaded below instead
      if (speed_valid && !speed_stall && state != EMIT) begin
        speed_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            last_alt <= sample.altitude_cm;
            if (!have_prev) begin
              for (int i = 0; i < AVG_DEPTH; i++) begin
                ring[i] <= '0;
              end
              slot      <= '0;
              total     <= '0;
              have_prev <= 1'b1;
              vs        <= '0;
              primed    <= 1'b1;
              state     <= EMIT;
            end else begin
              diff   <= $signed({sample.altitude_cm[ALT_W-1], sample.altitude_cm})
                      - $signed({last_alt[ALT_W-1], last_alt});
              dsr    <= (sample.elapsed_ms == '0) ? MS_W'(1) : sample.elapsed_ms;
              primed <= 1'b0;
              state  <= LOAD;
            end
          end
        end
        LOAD: begin
          acc   <= PROD_W'(dvd_load) << (PROD_W - RATE_W);
          neg   <= diff[ALT_W];
          rem   <= '0;
          cnt   <= CNT_W'(RATE_W - 1);
          state <= DIV;
        end
        DIV, FDIV: begin
          rem <= trial_ok ? alu_sum[MS_W-1:0] : trial_top[MS_W-1:0];
          acc <= {acc[PROD_W-2:0], trial_ok};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= (state == DIV) ? RING : FIN;
          end
        end
        RING: begin
          ring[slot] <= rate_new;
          total      <= total_next;
          slot       <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
          state      <= CHK;
        end
        CHK: begin
          dead  <= (tot_mag < TOTAL_W'(thr));
          acc   <= '0;
          cnt   <= CNT_W'(SCALE_W - 1);
          state <= MUL;
        end
        MUL: begin
          acc <= alu_sum;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= POW2 ? FIN : PREP;
          end
        end
        PREP: begin
          neg   <= acc[PROD_W-1];
          acc   <= PROD_W'(alu_sum[QW-1:0]) << FRAC_W;
          rem   <= '0;
          dsr   <= MS_W'(AVG_DEPTH);
          cnt   <= CNT_W'(QW - 1);
          state <= FDIV;
        end
        FIN: begin
          vs    <= fin_val;
          state <= EMIT;
        end
        EMIT: begin
          if (!speed_valid || !speed_stall) begin
            speed.vertical_speed <= vs;
            speed.primed_only    <= primed;
            speed_valid          <= 1'b1;
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= LAST_SLOT)
    else $error("ring slot past depth");

  a_prime_zero: assert property (@(posedge clk) disable iff (rst)
    speed_valid && speed.primed_only |-> speed.vertical_speed == '0)
    else $error("priming word with nonzero speed");

  a_prev_sticky: assert property (@(posedge clk) disable iff (rst)
    have_prev |=> have_prev)
    else $error("primed flag dropped without reset");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DIV || state == FDIV) |-> rem < dsr)
    else $error("divider remainder not below divisor");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |=> (state == DIV || state == RING))
    else $error("rate divide left early");
`endif

endmodule
